### rtl/core/amdd_pkg.sv
// Package for the accelerometer motion delta detector.
// Holds the item types, the data ready bit position and the per-axis motion check.
// No dependencies.
package amdd_pkg;

    localparam int unsigned AXIS_W         = 16;
    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned DATA_READY_BIT = 3;

    typedef logic        [AXIS_W-1:0] axis_raw_t;
    typedef logic signed [AXIS_W-1:0] axis_t;
    typedef logic        [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic  status_good;
        byte_t status_byte;
        logic  burst_good;
        byte_t x_low;
        byte_t x_high;
        byte_t y_low;
        byte_t y_high;
        byte_t z_low;
        byte_t z_high;
    } item_t;

    typedef struct packed {
        logic  step_ok;
        logic  sample_written;
        axis_t sample_x;
        axis_t sample_y;
        axis_t sample_z;
        logic  motion_written;
        logic  moved_x;
        logic  moved_y;
        logic  moved_z;
        logic  moved_any;
    } result_t;

    // True when |cur - prev| is strictly above the threshold.
    function automatic logic axis_moved(input axis_t cur, input axis_t prev,
                                        input axis_raw_t thr);
        logic signed [AXIS_W:0] diff;
        logic        [AXIS_W:0] mag;
        begin
            diff = {cur[AXIS_W-1], cur} - {prev[AXIS_W-1], prev};
            mag  = diff[AXIS_W] ? (AXIS_W+1)'(-diff) : (AXIS_W+1)'(diff);
            axis_moved = mag > {1'b0, thr};
        end
    endfunction

endpackage

### rtl/core/amdd_if.sv
// Channel interfaces of the motion delta detector: input item, result and configuration.
// Depends on amdd_pkg.
interface amdd_item_if;
    logic            valid;
    logic            ready;
    logic            status_good;
    amdd_pkg::byte_t status_byte;
    logic            burst_good;
    amdd_pkg::byte_t x_low;
    amdd_pkg::byte_t x_high;
    amdd_pkg::byte_t y_low;
    amdd_pkg::byte_t y_high;
    amdd_pkg::byte_t z_low;
    amdd_pkg::byte_t z_high;

    modport source (output valid, status_good, status_byte, burst_good, x_low, x_high,
                    y_low, y_high, z_low, z_high, input ready);
    modport sink   (input valid, status_good, status_byte, burst_good, x_low, x_high,
                    y_low, y_high, z_low, z_high, output ready);
endinterface

interface amdd_result_if;
    logic            valid;
    logic            ready;
    logic            step_ok;
    logic            sample_written;
    amdd_pkg::axis_t sample_x;
    amdd_pkg::axis_t sample_y;
    amdd_pkg::axis_t sample_z;
    logic            motion_written;
    logic            moved_x;
    logic            moved_y;
    logic            moved_z;
    logic            moved_any;

    modport source (output valid, step_ok, sample_written, sample_x, sample_y, sample_z,
                    motion_written, moved_x, moved_y, moved_z, moved_any, input ready);
    modport sink   (input valid, step_ok, sample_written, sample_x, sample_y, sample_z,
                    motion_written, moved_x, moved_y, moved_z, moved_any, output ready);
endinterface

interface amdd_cfg_if;
    logic                valid;
    logic                ready;
    amdd_pkg::axis_raw_t data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### rtl/core/amdd_in_reg.sv
// Input register of the motion delta detector.
// Depends on amdd_pkg and amdd_item_if.
module amdd_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    amdd_item_if.sink           item,
    input  logic                taken,
    output logic                valid,
    output amdd_pkg::item_t     data
);

    logic            valid_reg;
    logic            valid_next;
    amdd_pkg::item_t data_reg;
    logic            load;

    assign item.ready = !valid_reg || taken;
    assign load       = item.valid && item.ready;
    assign valid_next = load ? 1'b1 : (taken ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= '{status_good: item.status_good,
                          status_byte: item.status_byte,
                          burst_good:  item.burst_good,
                          x_low:       item.x_low,
                          x_high:      item.x_high,
                          y_low:       item.y_low,
                          y_high:      item.y_high,
                          z_low:       item.z_low,
                          z_high:      item.z_high};
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

### rtl/core/amdd_core.sv
// Evaluation stage: threshold register, previous sample state and the motion check.
// Depends on amdd_pkg and amdd_cfg_if.
module amdd_core (
    input  logic                clk,
    input  logic                rst_n,
    amdd_cfg_if.sink            cfg,
    input  amdd_pkg::item_t     item,
    input  logic                taken,
    output amdd_pkg::result_t   result
);

    amdd_pkg::axis_raw_t threshold_reg;
    amdd_pkg::axis_t     last_x_reg;
    amdd_pkg::axis_t     last_y_reg;
    amdd_pkg::axis_t     last_z_reg;
    logic                have_last_reg;
    amdd_pkg::axis_t     last_x_next;
    amdd_pkg::axis_t     last_y_next;
    amdd_pkg::axis_t     last_z_next;
    logic                have_last_next;
    amdd_pkg::axis_t     cur_x;
    amdd_pkg::axis_t     cur_y;
    amdd_pkg::axis_t     cur_z;
    logic                mx;
    logic                my;
    logic                mz;

    assign cfg.ready = 1'b1;

    assign cur_x = {item.x_high, item.x_low};
    assign cur_y = {item.y_high, item.y_low};
    assign cur_z = {item.z_high, item.z_low};

    assign mx = amdd_pkg::axis_moved(cur_x, last_x_reg, threshold_reg);
    assign my = amdd_pkg::axis_moved(cur_y, last_y_reg, threshold_reg);
    assign mz = amdd_pkg::axis_moved(cur_z, last_z_reg, threshold_reg);

    always_comb
    begin
        result         = '0;
        last_x_next    = last_x_reg;
        last_y_next    = last_y_reg;
        last_z_next    = last_z_reg;
        have_last_next = have_last_reg;
        priority if (!item.status_good)
        begin
            last_x_next           = '0;
            last_y_next           = '0;
            last_z_next           = '0;
            result.sample_written = 1'b1;
        end
        else if (!item.status_byte[amdd_pkg::DATA_READY_BIT])
        begin
            result.step_ok = 1'b1;
        end
        else if (!item.burst_good)
        begin
            last_x_next           = '0;
            last_y_next           = '0;
            last_z_next           = '0;
            result.sample_written = 1'b1;
        end
        else
        begin
            result.step_ok        = 1'b1;
            result.sample_written = 1'b1;
            result.sample_x       = cur_x;
            result.sample_y       = cur_y;
            result.sample_z       = cur_z;
            if (have_last_reg)
            begin
                result.motion_written = 1'b1;
                result.moved_x        = mx;
                result.moved_y        = my;
                result.moved_z        = mz;
                result.moved_any      = mx || my || mz;
            end
            last_x_next    = cur_x;
            last_y_next    = cur_y;
            last_z_next    = cur_z;
            have_last_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            last_z_reg    <= '0;
            have_last_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                threshold_reg <= cfg.data;
            end
            if (taken)
            begin
                last_x_reg    <= last_x_next;
                last_y_reg    <= last_y_next;
                last_z_reg    <= last_z_next;
                have_last_reg <= have_last_next;
            end
        end
    end

endmodule

### rtl/core/amdd_out_reg.sv
// Result register of the motion delta detector, drives the result channel.
// Depends on amdd_pkg and amdd_result_if.
module amdd_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  amdd_pkg::result_t   data,
    output logic                taken,
    amdd_result_if.source       result
);

    logic              valid_reg;
    logic              valid_next;
    amdd_pkg::result_t data_reg;

    assign taken      = in_valid && (!valid_reg || result.ready);
    assign valid_next = taken ? 1'b1 : (result.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (taken)
        begin
            data_reg <= data;
        end
    end

    assign result.valid          = valid_reg;
    assign result.step_ok        = data_reg.step_ok;
    assign result.sample_written = data_reg.sample_written;
    assign result.sample_x       = data_reg.sample_x;
    assign result.sample_y       = data_reg.sample_y;
    assign result.sample_z       = data_reg.sample_z;
    assign result.motion_written = data_reg.motion_written;
    assign result.moved_x        = data_reg.moved_x;
    assign result.moved_y        = data_reg.moved_y;
    assign result.moved_z        = data_reg.moved_z;
    assign result.moved_any      = data_reg.moved_any;

endmodule

### rtl/core/accel_motion_delta_detect_top.sv
// Top level of the accelerometer motion delta detector.
// Depends on amdd_pkg, the amdd interfaces, amdd_in_reg, amdd_core and amdd_out_reg.
//
//   Channel   Direction   Carries
//   item      in          status_good, status_byte, burst_good, six axis bytes
//   result    out         step_ok, sample flags and X/Y/Z, motion flags
//   cfg       in          motion_threshold write data
//
// One item per cycle is accepted while the result channel is not stalled; each item is
// held in the input register; its result is loaded into the result register and sent.
// The input register feeds the evaluation logic, which feeds the result register.
// Reset clears the valid flags, the previous sample and the threshold.
// A stalled result holds its register; the input register still takes one more item.
module accel_motion_delta_detect_top (
    input  logic            clk,
    input  logic            rst_n,
    amdd_item_if.sink       item,
    amdd_result_if.source   result,
    amdd_cfg_if.sink        cfg
);

    logic              stage_valid;
    logic              taken;
    amdd_pkg::item_t   stage_item;
    amdd_pkg::result_t stage_result;

    amdd_in_reg u_in_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .taken (taken),
        .valid (stage_valid),
        .data  (stage_item)
    );

    amdd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (stage_item),
        .taken  (taken),
        .result (stage_result)
    );

    amdd_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stage_valid),
        .data     (stage_result),
        .taken    (taken),
        .result   (result)
    );

endmodule

### rtl/core/amdd_checker.sv
// Port-level checks of the motion delta detector result channel.
// Depends on accel_motion_delta_detect_top, to which it is bound.
module amdd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        ready,
    input logic        step_ok,
    input logic        sample_written,
    input logic [15:0] sample_x,
    input logic [15:0] sample_y,
    input logic [15:0] sample_z,
    input logic        motion_written,
    input logic        moved_x,
    input logic        moved_y,
    input logic        moved_z,
    input logic        moved_any
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("result dropped while stalled");

    a_fail_shape: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !step_ok |-> sample_written && !motion_written &&
            sample_x == 16'd0 && sample_y == 16'd0 && sample_z == 16'd0)
        else $error("failed read result has wrong fields");

    a_any: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> moved_any == (moved_x || moved_y || moved_z))
        else $error("moved_any disagrees with axis flags");

    a_no_check: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !motion_written |-> !moved_x && !moved_y && !moved_z)
        else $error("motion flag set without a motion check");

    a_motion_sample: assert property (@(posedge clk) disable iff (!rst_n)
        valid && motion_written |-> step_ok && sample_written)
        else $error("motion check without a good sample");

endmodule

bind accel_motion_delta_detect_top amdd_checker u_amdd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid          (result.valid),
    .ready          (result.ready),
    .step_ok        (result.step_ok),
    .sample_written (result.sample_written),
    .sample_x       (result.sample_x),
    .sample_y       (result.sample_y),
    .sample_z       (result.sample_z),
    .motion_written (result.motion_written),
    .moved_x        (result.moved_x),
    .moved_y        (result.moved_y),
    .moved_z        (result.moved_z),
    .moved_any      (result.moved_any)
);

### tb/sv/amdd_motion_checker.sv
// Checker for the accelerometer motion delta detector: watches the item, result and cfg channels.
// Predicts each result from the accepted items and the threshold, then compares in order.
// Depends on amdd_pkg and the amdd channel interfaces.
module amdd_motion_checker
    import amdd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    amdd_item_if        item,
    amdd_result_if      result,
    amdd_cfg_if         cfg,
    output int unsigned fail_count,
    output int unsigned results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    axis_raw_t threshold;
    axis_raw_t last_x;
    axis_raw_t last_y;
    axis_raw_t last_z;
    logic      have_last;
    result_t   due_q[$];

    function automatic logic exceeds(input axis_raw_t cur, input axis_raw_t prev);
        int delta;
        delta = int'(axis_t'(cur)) - int'(axis_t'(prev));
        if (delta < 0)
        begin
            delta = -delta;
        end
        return delta > int'(threshold);
    endfunction

    function automatic result_t predict_reading(input item_t it);
        result_t   r;
        axis_raw_t cx;
        axis_raw_t cy;
        axis_raw_t cz;
        r = '0;
        r.step_ok = 1'b1;
        if (!it.status_good || (it.status_byte[DATA_READY_BIT] && !it.burst_good))
        begin
            last_x = '0;
            last_y = '0;
            last_z = '0;
            r.step_ok = 1'b0;
            r.sample_written = 1'b1;
        end
        else if (it.status_byte[DATA_READY_BIT])
        begin
            cx = {it.x_high, it.x_low};
            cy = {it.y_high, it.y_low};
            cz = {it.z_high, it.z_low};
            if (have_last)
            begin
                r.motion_written = 1'b1;
                r.moved_x = exceeds(cx, last_x);
                r.moved_y = exceeds(cy, last_y);
                r.moved_z = exceeds(cz, last_z);
                r.moved_any = r.moved_x | r.moved_y | r.moved_z;
            end
            have_last = 1'b1;
            last_x = cx;
            last_y = cy;
            last_z = cz;
            r.sample_written = 1'b1;
            r.sample_x = cx;
            r.sample_y = cy;
            r.sample_z = cz;
        end
        return r;
    endfunction

    function automatic string show(input result_t r);
        return $sformatf("ok=%0b sw=%0b x=%0d y=%0d z=%0d mw=%0b mx=%0b my=%0b mz=%0b any=%0b",
                         r.step_ok, r.sample_written, r.sample_x, r.sample_y, r.sample_z,
                         r.motion_written, r.moved_x, r.moved_y, r.moved_z, r.moved_any);
    endfunction

    task automatic report(input string msg);
        if (fail_count < 10)
        begin
            $display("%0t: %s", $realtime, msg);
        end
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        item_t   it;
        if (!rst_n)
        begin
            threshold = '0;
            last_x = '0;
            last_y = '0;
            last_z = '0;
            have_last = 1'b0;
            due_q.delete();
            fail_count = 0;
            results_due = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got.step_ok        = result.step_ok;
                got.sample_written = result.sample_written;
                got.sample_x       = result.sample_x;
                got.sample_y       = result.sample_y;
                got.sample_z       = result.sample_z;
                got.motion_written = result.motion_written;
                got.moved_x        = result.moved_x;
                got.moved_y        = result.moved_y;
                got.moved_z        = result.moved_z;
                got.moved_any      = result.moved_any;
                if (due_q.size() == 0)
                begin
                    report({"unexpected result: ", show(got)});
                end
                else
                begin
                    want = due_q.pop_front();
                    if (got !== want)
                    begin
                        report({"mismatch: expected ", show(want), " actual ", show(got)});
                    end
                end
            end
            if (item.valid && item.ready)
            begin
                it.status_good = item.status_good;
                it.status_byte = item.status_byte;
                it.burst_good  = item.burst_good;
                it.x_low       = item.x_low;
                it.x_high      = item.x_high;
                it.y_low       = item.y_low;
                it.y_high      = item.y_high;
                it.z_low       = item.z_low;
                it.z_high      = item.z_high;
                due_q.push_back(predict_reading(it));
            end
            if (cfg.valid && cfg.ready)
            begin
                threshold = cfg.data;
            end
            results_due = due_q.size();
        end
    end

endmodule

### tb/sv/tb_accel_motion_delta_detect_top.sv
// Testbench top for the accelerometer motion delta detector: clock, reset, stimulus, verdict.
// Drives directed and random readings under several thresholds with random stalls on both sides.
// Depends on amdd_pkg, the amdd interfaces, accel_motion_delta_detect_top and amdd_motion_checker.
module tb_accel_motion_delta_detect_top;
    timeunit 1ns;
    timeprecision 1ps;

    import amdd_pkg::*;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        calm  = 1'b0;
    int unsigned fail_count;
    int unsigned results_due;
    axis_raw_t   prev_x = '0;
    axis_raw_t   prev_y = '0;
    axis_raw_t   prev_z = '0;
    axis_raw_t   cur_thr = '0;

    amdd_item_if   item_ch();
    amdd_result_if result_ch();
    amdd_cfg_if    cfg_ch();

    accel_motion_delta_detect_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    amdd_motion_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .cfg         (cfg_ch),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic item_t mk_item(input logic st_good, input byte_t status,
                                      input logic b_good,
                                      input axis_raw_t x, input axis_raw_t y,
                                      input axis_raw_t z);
        item_t it;
        it.status_good = st_good;
        it.status_byte = status;
        it.burst_good  = b_good;
        {it.x_high, it.x_low} = x;
        {it.y_high, it.y_low} = y;
        {it.z_high, it.z_low} = z;
        return it;
    endfunction

    function automatic axis_raw_t near_value(input axis_raw_t prev);
        int          d;
        int unsigned span;
        if ($urandom_range(0, 2) == 0)
        begin
            return axis_raw_t'($urandom);
        end
        if (cur_thr > 1000 && $urandom_range(0, 1) == 1)
        begin
            d = int'(cur_thr) - 2 + int'($urandom_range(0, 4));
        end
        else
        begin
            span = (cur_thr > 1000) ? 1000 : cur_thr;
            d = int'($urandom_range(0, span + 2));
        end
        if ($urandom_range(0, 1) == 1)
        begin
            d = -d;
        end
        return axis_raw_t'(int'(axis_t'(prev)) + d);
    endfunction

    // Entered and left at a falling edge; valid stays high when no gap follows.
    task automatic send_item(input item_t it);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.status_good = it.status_good;
        item_ch.status_byte = it.status_byte;
        item_ch.burst_good  = it.burst_good;
        item_ch.x_low       = it.x_low;
        item_ch.x_high      = it.x_high;
        item_ch.y_low       = it.y_low;
        item_ch.y_high      = it.y_high;
        item_ch.z_low       = it.z_low;
        item_ch.z_high      = it.z_high;
        item_ch.valid       = 1'b1;
        do @(posedge clk); while (!item_ch.ready);
        if (!it.status_good || (it.status_byte[DATA_READY_BIT] && !it.burst_good))
        begin
            prev_x = '0;
            prev_y = '0;
            prev_z = '0;
        end
        else if (it.status_byte[DATA_READY_BIT])
        begin
            prev_x = {it.x_high, it.x_low};
            prev_y = {it.y_high, it.y_low};
            prev_z = {it.z_high, it.z_low};
        end
        @(negedge clk);
    endtask

    task automatic write_threshold(input axis_raw_t thr);
        item_ch.valid = 1'b0;
        while (results_due != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_ch.data  = thr;
        cfg_ch.valid = 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
        cur_thr = thr;
    endtask

    task automatic send_random_item();
        item_t       it;
        int unsigned r;
        r = $urandom_range(0, 99);
        it = mk_item(1'b1, byte_t'($urandom) | byte_t'(1 << DATA_READY_BIT), 1'b1,
                     near_value(prev_x), near_value(prev_y), near_value(prev_z));
        if (r < 5)
        begin
            it.status_good = 1'b0;
        end
        else if (r < 12)
        begin
            it.status_byte[DATA_READY_BIT] = 1'b0;
        end
        else if (r < 17)
        begin
            it.burst_good = 1'b0;
        end
        else if (r < 20)
        begin
            it.status_good = 1'($urandom_range(0, 1));
            it.burst_good  = 1'($urandom_range(0, 1));
            it.status_byte = byte_t'($urandom);
        end
        send_item(it);
    endtask

    initial
    begin
        int unsigned stall;
        stall = 0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall != 0)
            begin
                result_ch.ready = 1'b0;
                stall--;
            end
            else
            begin
                result_ch.ready = 1'b1;
                if ($urandom_range(0, 3) == 0)
                begin
                    stall = pick_gap();
                end
            end
        end
    end

    initial
    begin
        axis_raw_t thr;
        item_ch.valid       = 1'b0;
        item_ch.status_good = 1'b0;
        item_ch.status_byte = '0;
        item_ch.burst_good  = 1'b0;
        item_ch.x_low       = '0;
        item_ch.x_high      = '0;
        item_ch.y_low       = '0;
        item_ch.y_high      = '0;
        item_ch.z_low       = '0;
        item_ch.z_high      = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The threshold keeps its reset value for the first group.
        send_item(mk_item(1'b0, 8'hFF, 1'b1, 16'h1234, 16'h5678, 16'h9ABC));
        send_item(mk_item(1'b1, 8'hF7, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(mk_item(1'b1, 8'h08, 1'b0, 16'h4321, 16'h8765, 16'hCBA9));
        send_item(mk_item(1'b1, 8'hFF, 1'b1, 16'h7FFF, 16'h8000, 16'h0000));
        send_item(mk_item(1'b1, 8'h08, 1'b1, 16'h8000, 16'h7FFF, 16'h0001));
        send_item(mk_item(1'b1, 8'h08, 1'b1, 16'h8000, 16'h7FFF, 16'h0001));
        send_item(mk_item(1'b1, 8'h00, 1'b0, 16'hFFFF, 16'h0000, 16'hFFFF));
        send_item(mk_item(1'b0, 8'h00, 1'b0, 16'h0000, 16'hFFFF, 16'h0000));
        send_item(mk_item(1'b1, 8'h08, 1'b1, 16'hFFFF, 16'h0001, 16'h8000));

        write_threshold(16'hFFFF);
        send_item(mk_item(1'b1, 8'h08, 1'b1, 16'h7FFF, 16'h8000, 16'h0000));
        send_item(mk_item(1'b1, 8'h08, 1'b1, 16'h8000, 16'h7FFF, 16'hFFFF));

        write_threshold(16'h0001);
        send_item(mk_item(1'b1, 8'h08, 1'b1, 16'h0000, 16'h0000, 16'h0000));
        send_item(mk_item(1'b1, 8'h08, 1'b1, 16'h0001, 16'hFFFE, 16'h0000));

        write_threshold(16'h7FFF);
        send_item(mk_item(1'b1, 8'h08, 1'b1, 16'h8000, 16'h7FFF, 16'h8000));
        send_item(mk_item(1'b1, 8'h08, 1'b1, 16'hFFFF, 16'hFFFF, 16'h7FFF));
        send_item(mk_item(1'b1, 8'h08, 1'b1, 16'h7FFF, 16'h8000, 16'hFFFF));

        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0: thr = 16'h0000;
                1: thr = 16'hFFFF;
                2: thr = axis_raw_t'($urandom_range(0, 300));
                default: thr = axis_raw_t'($urandom);
            endcase
            write_threshold(thr);
            for (int n = 0; n < 150; n++)
            begin
                if ($urandom_range(0, 39) == 0)
                begin
                    calm = ~calm;
                end
                send_random_item();
            end
        end

        item_ch.valid = 1'b0;
        while (results_due != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0 && results_due == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
